/* rtl/mps_pkg.sv */
package mps_pkg;

  // Channel count and derived widths
  localparam int NUM_SERVOS = 3;
  localparam int CH_W       = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  // Field widths
  localparam int TICK_W  = 16;
  localparam int LIMIT_W = 8;
  localparam int PINS_W  = 3;
  localparam int BTN_W   = 3;
  localparam int CHAN_W  = 2;
  localparam int CIDX_W  = 3;

  // Stream payload widths (whole bytes)
  localparam int IN_DATA_W  = 8;
  localparam int OUT_FLD_W  = PINS_W + TICK_W + CHAN_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // Operation codes
  localparam logic OP_OVERFLOW = 1'b0;
  localparam logic OP_POLL     = 1'b1;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_SLOT_CONSTANT  = 3'd0,
    CFG_LEFT_TICKS     = 3'd1,
    CFG_RIGHT_TICKS    = 3'd2,
    CFG_CENTER_TICKS   = 3'd3,
    CFG_DEBOUNCE_LIMIT = 3'd4
  } cfg_idx_t;

  // Reset values
  localparam logic [TICK_W-1:0]  SLOT_RST   = 16'd64870;
  localparam logic [TICK_W-1:0]  LEFT_RST   = 16'd900;
  localparam logic [TICK_W-1:0]  RIGHT_RST  = 16'd1900;
  localparam logic [TICK_W-1:0]  CENTER_RST = 16'd1400;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 8'd200;

  // Live configuration seen by the step logic
  typedef struct packed {
    logic [TICK_W-1:0]  slot_constant;
    logic [TICK_W-1:0]  left_ticks;
    logic [TICK_W-1:0]  right_ticks;
    logic [LIMIT_W-1:0] debounce_limit;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [PINS_W-1:0] servo_pins;
    logic [TICK_W-1:0] timer_reload;
    logic              reload_valid;
    logic [CHAN_W-1:0] active_channel;
  } result_t;

endpackage

/* rtl/mps_cfg.sv */
module mps_cfg
  import mps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [CIDX_W-1:0] wr_index,
  input  logic [TICK_W-1:0] wr_data,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; center_ticks only matters at reset, so it is not held
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_SLOT_CONSTANT:  cfg_nxt.slot_constant  = wr_data;
        CFG_LEFT_TICKS:     cfg_nxt.left_ticks     = wr_data;
        CFG_RIGHT_TICKS:    cfg_nxt.right_ticks    = wr_data;
        CFG_DEBOUNCE_LIMIT: cfg_nxt.debounce_limit = wr_data[LIMIT_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_constant  <= SLOT_RST;
      cfg_r.left_ticks     <= LEFT_RST;
      cfg_r.right_ticks    <= RIGHT_RST;
      cfg_r.debounce_limit <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/mps_step.sv */
module mps_step
  import mps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             op,
  input  logic [BTN_W-1:0] buttons,
  input  cfg_t             cfg,
  output result_t          result
);

  logic [CH_W-1:0]    chan_r, chan_nxt;
  logic [PINS_W-1:0]  pins_r, pins_nxt;
  logic [TICK_W-1:0]  pos_r    [NUM_SERVOS];
  logic [TICK_W-1:0]  pos_nxt  [NUM_SERVOS];
  logic [NUM_SERVOS-1:0] stable_r, stable_nxt;
  logic [LIMIT_W-1:0] cnt_r    [NUM_SERVOS];
  logic [LIMIT_W-1:0] cnt_nxt  [NUM_SERVOS];
  logic [LIMIT_W-1:0] cnt_inc  [NUM_SERVOS];
  logic [PINS_W-1:0]  bit_sel;
  logic [TICK_W-1:0]  pos_cur;
  logic [TICK_W-1:0]  reload;

  // On an overflow, toggle the active pin, pick the reload value and advance the channel when the pin falls
  always_comb begin
    bit_sel  = PINS_W'(1) << chan_r;
    pos_cur  = pos_r[chan_r];
    chan_nxt = chan_r;
    pins_nxt = pins_r;
    reload   = '0;
    if (op == OP_OVERFLOW) begin
      pins_nxt = pins_r ^ bit_sel;
      if ((pins_nxt & bit_sel) != '0) begin
        reload = TICK_W'(0) - pos_cur;
      end else begin
        reload = cfg.slot_constant - pos_cur;
        if (chan_r == CH_W'(NUM_SERVOS - 1)) begin
          chan_nxt = '0;
        end else begin
          chan_nxt = chan_r + CH_W'(1);
        end
      end
    end
  end

  // Debounce each button on a poll tick
  always_comb begin
    stable_nxt = stable_r;
    for (int i = 0; i < NUM_SERVOS; i++) begin
      pos_nxt[i] = pos_r[i];
      cnt_nxt[i] = cnt_r[i];
      cnt_inc[i] = cnt_r[i] + LIMIT_W'(1);
      if (op == OP_POLL) begin
        if (buttons[i] != stable_r[i]) begin
          cnt_nxt[i] = cnt_inc[i];
          if (cnt_inc[i] > cfg.debounce_limit) begin
            cnt_nxt[i]    = '0;
            stable_nxt[i] = ~stable_r[i];
            pos_nxt[i]    = stable_r[i] ? cfg.right_ticks : cfg.left_ticks;
          end
        end else begin
          cnt_nxt[i] = '0;
        end
      end
    end
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r   <= '0;
      pins_r   <= '0;
      stable_r <= '0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        pos_r[i] <= CENTER_RST;
        cnt_r[i] <= '0;
      end
    end else if (fire) begin
      chan_r   <= chan_nxt;
      pins_r   <= pins_nxt;
      stable_r <= stable_nxt;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        pos_r[i] <= pos_nxt[i];
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // Build the result item
  always_comb begin
    result.servo_pins     = pins_nxt;
    result.timer_reload   = reload;
    result.reload_valid   = (op == OP_OVERFLOW);
    result.active_channel = CHAN_W'(chan_nxt);
  end

endmodule

/* rtl/multiplexed_servo_pulse_scheduler_top.sv */
// Channel  Dir  Payload
// in_      in   tdata[2:0] button_levels, tuser[0] operation
// out_     out  tdata[2:0] servo_pins, [18:3] timer_reload, [20:19] active_channel;
//               tuser[0] reload_valid
// cfg_     in   cfg_index register, cfg_data value (debounce_limit uses bits 7:0)
//
// One transaction per cycle sustained while out_tready is high; the path runs from the
// input register to the result register, with the step logic between them.
// rst_n is synchronous: all pins low, channel 0, positions 1400, registers at
// their defaults. cfg_ready is always high.
// A stalled out_ holds its result; the input register still takes a new item whenever it is
// empty or the result register is free or being drained in the same cycle.
module multiplexed_servo_pulse_scheduler_top
  import mps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [2:0] button_levels
  input  logic [0:0]            in_tuser,   // [0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // servo_pins, timer_reload, active_channel
  output logic [0:0]            out_tuser,  // [0] reload_valid
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CIDX_W-1:0]     cfg_index,
  input  logic [TICK_W-1:0]     cfg_data
);

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_op_r;
  logic [BTN_W-1:0] s1_btn_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;
  result_t          step_res;
  cfg_t             cfg;
  logic             out_free;
  logic             s1_fire;
  logic             in_fire;

  // Handshake control
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  mps_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mps_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .op      (s1_op_r),
    .buttons (s1_btn_r),
    .cfg     (cfg),
    .result  (step_res)
  );

  // Advance the valid flags
  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_tuser[0];
      s1_btn_r <= in_tdata[BTN_W-1:0];
    end
    if (s1_fire) begin
      out_res_r <= step_res;
    end
  end

  // Pack the result
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.reload_valid;
  assign out_tdata  = OUT_DATA_W'({out_res_r.active_channel,
                                   out_res_r.timer_reload,
                                   out_res_r.servo_pins});

endmodule
